// ===== design/tracs_pkg.sv =====
`timescale 1ns / 1ps

package tracs_pkg;

  // Data path geometry
  localparam int WORD_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int MEM_DEPTH = 16;
  localparam int CMD_W     = 4;
  localparam int OPND_W    = 4;
  localparam int KIND_W    = 2;

  // Item kinds on the opcode field
  localparam logic [KIND_W-1:0] OPC_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] OPC_READ  = 2'd1;
  localparam logic [KIND_W-1:0] OPC_EXEC  = 2'd2;

  // Instruction commands
  localparam logic [CMD_W-1:0] CMD_NOP   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SAVEA = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SAVEB = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LOADA = 4'd3;
  localparam logic [CMD_W-1:0] CMD_LOADB = 4'd4;
  localparam logic [CMD_W-1:0] CMD_ADDA  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADDB  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_JUMP  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_IFA   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_IFB   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_END   = 4'd10;

  // State update produced by one item
  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] pc_next;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W-1:0] b_next;
  } upd_t;

endpackage

// ===== design/two_register_accumulator_cpu_step_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake                    | Payload
// --------+------------------------------+-----------------------------------------------
// in      | in_valid / in_stall          | opcode, address, write_data
// out     | out_valid / out_stall        | program_counter, reg_a, reg_b, read_data,
//         |                              | executed_command, end_seen
//
// One item per cycle while the output does not stall; each item passes the input
// register and then the result register before its result is offered.
// The item is registered, then executes against the register file and core
// registers in one pass, and the result is registered for the output.
// Synchronous reset clears pc, A, B, all memory words and both valid flags.
// A stall on the output holds the result and the waiting item; input stalls
// only while both stages are full and the output stalls.

module two_register_accumulator_cpu_step_top import tracs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] opcode,
  input  logic [ADDR_W-1:0] address,
  input  logic [WORD_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] program_counter,
  output logic [WORD_W-1:0] reg_a,
  output logic [WORD_W-1:0] reg_b,
  output logic [WORD_W-1:0] read_data,
  output logic [CMD_W-1:0]  executed_command,
  output logic              end_seen
);

  logic              s1_valid;
  logic [KIND_W-1:0] s1_opcode;
  logic [ADDR_W-1:0] s1_address;
  logic [WORD_W-1:0] s1_write_data;
  logic              advance;

  logic [ADDR_W-1:0] pc;
  logic [WORD_W-1:0] acc_a;
  logic [WORD_W-1:0] acc_b;
  logic [WORD_W-1:0] fetch_word;
  logic [WORD_W-1:0] opnd_word;
  logic [WORD_W-1:0] rd_word;
  logic [ADDR_W-1:0] ea;
  upd_t              upd;
  logic [WORD_W-1:0] rd_after;
  logic [CMD_W-1:0]  cmd_now;
  logic              end_now;

  // Execute the held item when the result register can take it
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_opcode     <= opcode;
      s1_address    <= address;
      s1_write_data <= write_data;
    end
  end

  tracs_state u_state (
    .clk        (clk),
    .rst        (rst),
    .upd_en     (advance),
    .upd        (upd),
    .ea         (ea),
    .rd_addr    (s1_address),
    .pc         (pc),
    .acc_a      (acc_a),
    .acc_b      (acc_b),
    .fetch_word (fetch_word),
    .opnd_word  (opnd_word),
    .rd_word    (rd_word)
  );

  tracs_exec u_exec (
    .opcode           (s1_opcode),
    .address          (s1_address),
    .write_data       (s1_write_data),
    .pc               (pc),
    .acc_a            (acc_a),
    .acc_b            (acc_b),
    .fetch_word       (fetch_word),
    .opnd_word        (opnd_word),
    .rd_word          (rd_word),
    .ea               (ea),
    .upd              (upd),
    .read_data        (rd_after),
    .executed_command (cmd_now),
    .end_seen         (end_now)
  );

  // Result register: load on advance, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      program_counter  <= upd.pc_next;
      reg_a            <= upd.a_next;
      reg_b            <= upd.b_next;
      read_data        <= rd_after;
      executed_command <= cmd_now;
      end_seen         <= end_now;
    end
  end

endmodule

// ===== design/tracs_state.sv =====
`timescale 1ns / 1ps

module tracs_state import tracs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd_en,
  input  upd_t              upd,
  input  logic [ADDR_W-1:0] ea,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ADDR_W-1:0] pc,
  output logic [WORD_W-1:0] acc_a,
  output logic [WORD_W-1:0] acc_b,
  output logic [WORD_W-1:0] fetch_word,
  output logic [WORD_W-1:0] opnd_word,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0] mem [MEM_DEPTH];

  // Register file: cleared on reset, at most one write per item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
        mem[i] <= '0;
      end
    end else if (upd_en && upd.mem_we) begin
      mem[upd.mem_waddr] <= upd.mem_wdata;
    end
  end

  // Core registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= '0;
      acc_a <= '0;
      acc_b <= '0;
    end else if (upd_en) begin
      pc    <= upd.pc_next;
      acc_a <= upd.a_next;
      acc_b <= upd.b_next;
    end
  end

  // Read ports: fetch, operand, item address
  assign fetch_word = mem[pc];
  assign opnd_word  = mem[ea];
  assign rd_word    = mem[rd_addr];

endmodule

// ===== design/tracs_exec.sv =====
`timescale 1ns / 1ps

module tracs_exec import tracs_pkg::*; (
  input  logic [KIND_W-1:0] opcode,
  input  logic [ADDR_W-1:0] address,
  input  logic [WORD_W-1:0] write_data,
  input  logic [ADDR_W-1:0] pc,
  input  logic [WORD_W-1:0] acc_a,
  input  logic [WORD_W-1:0] acc_b,
  input  logic [WORD_W-1:0] fetch_word,
  input  logic [WORD_W-1:0] opnd_word,
  input  logic [WORD_W-1:0] rd_word,
  output logic [ADDR_W-1:0] ea,
  output upd_t              upd,
  output logic [WORD_W-1:0] read_data,
  output logic [CMD_W-1:0]  executed_command,
  output logic              end_seen
);

  logic [CMD_W-1:0]  cmd;
  logic [OPND_W-1:0] opnd;
  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] pc_rel;

  // Split the fetched word and form pc-relative addresses
  assign cmd    = fetch_word[WORD_W-1:OPND_W];
  assign opnd   = fetch_word[OPND_W-1:0];
  assign pc_rel = pc + opnd;
  assign pc_inc = pc + ADDR_W'(1);
  assign ea     = pc_rel;

  // Decode the item and build the state update
  always_comb begin
    upd.mem_we       = 1'b0;
    upd.mem_waddr    = address;
    upd.mem_wdata    = write_data;
    upd.pc_next      = pc;
    upd.a_next       = acc_a;
    upd.b_next       = acc_b;
    executed_command = '0;
    end_seen         = 1'b0;
    case (opcode)
      OPC_WRITE: begin
        upd.mem_we = 1'b1;
      end
      OPC_EXEC: begin
        executed_command = cmd;
        upd.pc_next      = pc_inc;
        upd.mem_waddr    = ea;
        case (cmd)
          CMD_SAVEA: begin
            upd.mem_we    = 1'b1;
            upd.mem_wdata = acc_a;
          end
          CMD_SAVEB: begin
            upd.mem_we    = 1'b1;
            upd.mem_wdata = acc_b;
          end
          CMD_LOADA: upd.a_next = opnd_word;
          CMD_LOADB: upd.b_next = opnd_word;
          CMD_ADDA:  upd.a_next = acc_a + opnd_word;
          CMD_ADDB:  upd.b_next = acc_b + opnd_word;
          CMD_JUMP:  upd.pc_next = pc_rel;
          CMD_IFA: begin
            if (acc_a != '0) upd.pc_next = pc_rel;
          end
          CMD_IFB: begin
            if (acc_b != '0) upd.pc_next = pc_rel;
          end
          CMD_END:   end_seen = 1'b1;
          default: begin
            // nop and unknown commands only advance pc
          end
        endcase
      end
      default: begin
        // read and the unused kind leave state alone
      end
    endcase
  end

  // Word at the item address after this item's write
  assign read_data = (upd.mem_we && upd.mem_waddr == address) ? upd.mem_wdata : rd_word;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench import tracs_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 925;
  localparam int PLAN_LEN     = 26;
  localparam int DRAIN_CYCLES = 8;

  // Item kind with no defined action, and a command code with no meaning
  localparam logic [KIND_W-1:0] OPC_SPARE  = 2'd3;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 4'd15;

  // Everything one result reports
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] rd;
    logic [CMD_W-1:0]  cmd;
    logic              ended;
  } core_view_t;

  // One stimulus row; typed_in rows carry their own expected view
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              typed_in;
    core_view_t        want;
  } stim_row_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] opcode     = '0;
  logic [ADDR_W-1:0] address    = '0;
  logic [WORD_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [ADDR_W-1:0] program_counter;
  logic [WORD_W-1:0] reg_a;
  logic [WORD_W-1:0] reg_b;
  logic [WORD_W-1:0] read_data;
  logic [CMD_W-1:0]  executed_command;
  logic              end_seen;

  // Core image kept by the bench
  logic [ADDR_W-1:0] pc_model;
  logic [WORD_W-1:0] a_model;
  logic [WORD_W-1:0] b_model;
  logic [WORD_W-1:0] mem_image [MEM_DEPTH];

  core_view_t expected_views [$];
  int         mismatch_count = 0;
  int         burst_left     = 0;
  int         cycle_count    = 0;

  // Directed program: a spare-kind item and a write on the cleared core, then a short program that
  // walks every command, wraps addresses and ends in a jump onto itself
  stim_row_t plan [0:PLAN_LEN-1] = '{
    '{OPC_SPARE, 4'd0,  8'h00, 1'b1, '{4'd0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0}},
    '{OPC_WRITE, 4'd15, 8'hFF, 1'b1, '{4'd0, 8'h00, 8'h00, 8'hFF, 4'd0, 1'b0}},
    '{OPC_WRITE, 4'd0,  {CMD_LOADA, 4'd15},  1'b0, '0},
    '{OPC_WRITE, 4'd1,  {CMD_ADDA, 4'd15},   1'b0, '0},
    '{OPC_WRITE, 4'd2,  {CMD_SAVEA, 4'd14},  1'b0, '0},
    '{OPC_WRITE, 4'd3,  {CMD_LOADB, 4'd12},  1'b0, '0},
    '{OPC_WRITE, 4'd4,  {CMD_ADDB, 4'd11},   1'b0, '0},
    '{OPC_WRITE, 4'd5,  {CMD_SAVEB, 4'd10},  1'b0, '0},
    '{OPC_WRITE, 4'd6,  {CMD_IFA, 4'd2},     1'b0, '0},
    '{OPC_WRITE, 4'd8,  {CMD_IFB, 4'd2},     1'b0, '0},
    '{OPC_WRITE, 4'd11, {CMD_END, 4'd0},     1'b0, '0},
    '{OPC_WRITE, 4'd12, {CMD_UNUSED, 4'd0},  1'b0, '0},
    '{OPC_WRITE, 4'd13, {CMD_JUMP, 4'd0},    1'b0, '0},
    '{OPC_EXEC,  4'd15, 8'hA5, 1'b0, '0},
    '{OPC_EXEC,  4'd0,  8'h5A, 1'b0, '0},
    '{OPC_EXEC,  4'd0,  8'hFF, 1'b0, '0},
    '{OPC_EXEC,  4'd15, 8'h00, 1'b0, '0},
    '{OPC_EXEC,  4'd15, 8'h0F, 1'b0, '0},
    '{OPC_EXEC,  4'd15, 8'hF0, 1'b0, '0},
    '{OPC_EXEC,  4'd6,  8'h33, 1'b0, '0},
    '{OPC_EXEC,  4'd8,  8'hCC, 1'b0, '0},
    '{OPC_EXEC,  4'd10, 8'h00, 1'b0, '0},
    '{OPC_EXEC,  4'd11, 8'h00, 1'b0, '0},
    '{OPC_EXEC,  4'd12, 8'h00, 1'b0, '0},
    '{OPC_EXEC,  4'd13, 8'h00, 1'b0, '0},
    '{OPC_EXEC,  4'd13, 8'h00, 1'b0, '0}
  };

  two_register_accumulator_cpu_step_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .address          (address),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .program_counter  (program_counter),
    .reg_a            (reg_a),
    .reg_b            (reg_b),
    .read_data        (read_data),
    .executed_command (executed_command),
    .end_seen         (end_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one item to the core image and return what the block should report
  function automatic core_view_t step_core(input logic [KIND_W-1:0] kind,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [WORD_W-1:0] data);
    logic [WORD_W-1:0] word;
    logic [OPND_W-1:0] opnd;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] next_pc;
    core_view_t        view;
    view = '0;
    if (kind == OPC_WRITE) begin
      mem_image[addr] = data;
    end else if (kind == OPC_EXEC) begin
      word    = mem_image[pc_model];
      view.cmd = word[OPND_W +: CMD_W];
      opnd    = word[OPND_W-1:0];
      target  = pc_model + opnd;
      next_pc = pc_model + 1'b1;
      case (view.cmd)
        CMD_SAVEA: mem_image[target] = a_model;
        CMD_SAVEB: mem_image[target] = b_model;
        CMD_LOADA: a_model = mem_image[target];
        CMD_LOADB: b_model = mem_image[target];
        CMD_ADDA:  a_model = a_model + mem_image[target];
        CMD_ADDB:  b_model = b_model + mem_image[target];
        CMD_JUMP:  next_pc = target;
        CMD_IFA:   if (a_model != '0) next_pc = target;
        CMD_IFB:   if (b_model != '0) next_pc = target;
        default: ;
      endcase
      pc_model   = next_pc;
      view.ended = (view.cmd == CMD_END);
    end
    view.pc = pc_model;
    view.a  = a_model;
    view.b  = b_model;
    view.rd = mem_image[addr];
    return view;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Hold the item until its transfer, then record what it should produce
  task automatic send_item(input stim_row_t row);
    core_view_t predicted;
    in_valid   <= 1'b1;
    opcode     <= row.kind;
    address    <= row.addr;
    write_data <= row.data;
    do @(posedge clk); while (in_stall);
    predicted = step_core(row.kind, row.addr, row.data);
    expected_views.push_back(row.typed_in ? row.want : predicted);
  endtask

  // Burst pacing: between bursts drop valid for a gap, or wait for all results
  task automatic pace(input bit drain_now);
    int gap;
    if (burst_left == 0 || drain_now) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      if (drain_now || $urandom_range(39) == 0) begin
        do @(posedge clk); while (expected_views.size() != 0);
      end else begin
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Receiver: stall on a pattern whose mode is redrawn at random after each phase
  initial begin
    int stall_mode;
    int phase_len;
    forever begin
      stall_mode = $urandom_range(3);
      phase_len  = $urandom_range(10, 120);
      repeat (phase_len) begin
        @(posedge clk);
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(3) == 0);
          2:       out_stall <= ($urandom_range(3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    core_view_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result, expected none actual pc=%0h a=%0h b=%0h",
                 $time, program_counter, reg_a, reg_b);
        mismatch_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("program_counter", want.pc, program_counter);
        check_field("reg_a", want.a, reg_a);
        check_field("reg_b", want.b, reg_b);
        check_field("read_data", want.rd, read_data);
        check_field("executed_command", want.cmd, executed_command);
        check_field("end_seen", want.ended, end_seen);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t row;
    int        roll;
    pc_model = '0;
    a_model  = '0;
    b_model  = '0;
    for (int k = 0; k < MEM_DEPTH; k++) mem_image[k] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < PLAN_LEN; k++) begin
      pace(1'b0);
      send_item(plan[k]);
    end

    // Random traffic: mostly writes near pc and execute steps, some noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pace(k == RANDOM_ITEMS / 2);
      row  = '0;
      roll = $urandom_range(99);
      if (roll < 3)       row.kind = OPC_SPARE;
      else if (roll < 15) row.kind = OPC_READ;
      else if (roll < 50) row.kind = OPC_WRITE;
      else                row.kind = OPC_EXEC;
      row.addr = ($urandom_range(1) == 0) ? pc_model + ADDR_W'($urandom_range(3))
                                          : ADDR_W'($urandom_range(15));
      roll = $urandom_range(19);
      if (roll == 0)
        row.data = '0;
      else if (roll < 15)
        row.data = {CMD_W'($urandom_range(CMD_END)), OPND_W'($urandom)};
      else
        row.data = WORD_W'($urandom);
      send_item(row);
    end

    // Wait out the last results, then give the pipeline time to misbehave
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tracs_pkg.sv
design/tracs_state.sv
design/tracs_exec.sv
design/two_register_accumulator_cpu_step_top.sv
bench/testbench.sv
